[rtl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types, codes and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int ARENA_COUNT_DEF     = 2;
    localparam int PAGES_PER_ARENA_DEF = 1024;

    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int PAGE_OFS_W = 12;
    localparam int ADDR_W     = 32;
    localparam int BASE_W     = 20;
    localparam int PAGES_W    = 11;
    localparam int CFG_ARENAS = 2;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2
    } cmd_code_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OOM        = 2'd1,
        ST_MISALIGNED = 2'd2,
        ST_OUTSIDE    = 2'd3
    } status_code_t;

    typedef enum logic [1:0] {
        REG_ARENA0_BASE  = 2'd0,
        REG_ARENA0_PAGES = 2'd1,
        REG_ARENA1_BASE  = 2'd2,
        REG_ARENA1_PAGES = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [BASE_W-1:0]  base_frame;
        logic [PAGES_W-1:0] pages;
    } arena_cfg_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SEARCH,
        FSM_LOCATE,
        FSM_READ,
        FSM_EVAL,
        FSM_REPLY
    } fsm_state_t;

    typedef enum logic {
        OUT_SEL_EVAL,
        OUT_SEL_PLAIN
    } out_sel_t;

    typedef struct packed {
        logic     req_ready;
        logic     clear_step;
        logic     search;
        logic     locate;
        logic     mem_read;
        logic     skip_word;
        logic     mem_write;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] req_command;
        logic       clear_last;
        logic       target_ok;
        logic       word_exhausted;
        logic       out_free;
    } dp_status_t;

endpackage

[rtl/bpfa_if.sv]
// ----------------------------------------------------------------------------
// bpfa_if
// Request and response channels of the page frame allocator.
// ----------------------------------------------------------------------------
interface bpfa_req_if import bpfa_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [ADDR_W-1:0] phys_addr;

    modport source (output valid, output command, output phys_addr, input ready);
    modport sink   (input valid, input command, input phys_addr, output ready);
endinterface

interface bpfa_rsp_if import bpfa_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_addr;
    logic [1:0]        status;

    modport source (output valid, output result_addr, output status, input ready);
    modport sink   (input valid, input result_addr, input status, output ready);
endinterface

[rtl/bitmap_page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit 4 KiB page frame allocator over a used-page bitmap per arena.
// ----------------------------------------------------------------------------
//  channel  kind     direction  beat contents
//  req      valid/ready  in     command, phys_addr
//  rsp      valid/ready  out    result_addr, status
//  apb      APB      in/out     arena base frames and page counts
//
//  Allocate searches, reads and updates; free and reserve look up, read and
//  update. Each exhausted partial last word met by an allocate adds another
//  search, read and check. Unused command codes go straight to the reply.
//  The single bitmap port sets the pace. After reset a clearing pass zeroes
//  ARENA_COUNT*ceil(PAGES_PER_ARENA/32) words (64 by default), req.ready low.
//  A result waiting on rsp does not block a new req beat.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator import bpfa_pkg::*;
#(
    parameter int ARENA_COUNT     = ARENA_COUNT_DEF,
    parameter int PAGES_PER_ARENA = PAGES_PER_ARENA_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    bpfa_req_if.sink           req,
    bpfa_rsp_if.source         rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    arena_cfg_t arena_cfg [ARENA_COUNT];
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    bpfa_regs #(
        .ARENA_COUNT (ARENA_COUNT)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .arena_cfg (arena_cfg)
    );

    bpfa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (dp_status),
        .cmd    (dp_cmd)
    );

    bpfa_datapath #(
        .ARENA_COUNT     (ARENA_COUNT),
        .PAGES_PER_ARENA (PAGES_PER_ARENA)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .arena_cfg (arena_cfg),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

endmodule

[rtl/bpfa_regs.sv]
// ----------------------------------------------------------------------------
// bpfa_regs
// APB register bank holding base frame and page count of each arena.
// ----------------------------------------------------------------------------
module bpfa_regs import bpfa_pkg::*;
#(
    parameter int ARENA_COUNT = ARENA_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output arena_cfg_t         arena_cfg [ARENA_COUNT]
);

    arena_cfg_t cfg_reg  [CFG_ARENAS];
    arena_cfg_t cfg_next [CFG_ARENAS];
    reg_index_t reg_sel;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ARENA0_BASE:  cfg_next[0].base_frame = pwdata[BASE_W-1:0];
                REG_ARENA0_PAGES: cfg_next[0].pages      = pwdata[PAGES_W-1:0];
                REG_ARENA1_BASE:  cfg_next[1].base_frame = pwdata[BASE_W-1:0];
                REG_ARENA1_PAGES: cfg_next[1].pages      = pwdata[PAGES_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_ARENAS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ARENA0_BASE:  prdata = PDATA_W'(cfg_reg[0].base_frame);
            REG_ARENA0_PAGES: prdata = PDATA_W'(cfg_reg[0].pages);
            REG_ARENA1_BASE:  prdata = PDATA_W'(cfg_reg[1].base_frame);
            REG_ARENA1_PAGES: prdata = PDATA_W'(cfg_reg[1].pages);
            default:          prdata = '0;
        endcase
    end

    // arenas without registers stay empty
    for (genvar a = 0; a < ARENA_COUNT; a++)
    begin : g_cfg
        if (a < CFG_ARENAS)
        begin : g_live
            assign arena_cfg[a] = cfg_reg[a];
        end
        else
        begin : g_empty
            assign arena_cfg[a] = '0;
        end
    end

endmodule

[rtl/bpfa_datapath.sv]
// ----------------------------------------------------------------------------
// bpfa_datapath
// Bitmap memory, full-word summary, free-word search, arena lookup,
// bit update and response register.
// ----------------------------------------------------------------------------
module bpfa_datapath import bpfa_pkg::*;
#(
    parameter int ARENA_COUNT     = ARENA_COUNT_DEF,
    parameter int PAGES_PER_ARENA = PAGES_PER_ARENA_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    bpfa_req_if.sink   req,
    bpfa_rsp_if.source rsp,
    input  arena_cfg_t arena_cfg [ARENA_COUNT],
    input  dp_cmd_t    cmd,
    output dp_status_t status
);

    localparam int WPA          = (PAGES_PER_ARENA + WORD_BITS - 1) / WORD_BITS;
    localparam int BITMAP_WORDS = ARENA_COUNT * WPA;
    localparam int IDX_W        = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int ARENA_W      = (ARENA_COUNT > 1) ? $clog2(ARENA_COUNT) : 1;
    localparam int WORD_W       = (WPA > 1) ? $clog2(WPA) : 1;
    localparam int PAGE_W       = $clog2(PAGES_PER_ARENA);
    localparam int CNT_RAW_W    = $clog2(PAGES_PER_ARENA + 1);
    localparam int CNT_W        = ((CNT_RAW_W > PAGES_W) ? CNT_RAW_W : PAGES_W) + 1;

    // request and control registers
    logic [1:0]              op_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [BITMAP_WORDS-1:0] full_reg, full_next;
    logic [BITMAP_WORDS-1:0] skip_reg, skip_next;
    logic [IDX_W-1:0]        clear_idx_reg;
    logic                    found_reg;
    logic                    loc_ok_reg;
    logic                    misaligned_reg;
    logic [IDX_W-1:0]        tgt_idx_reg;
    logic [ARENA_W-1:0]      tgt_arena_reg;
    logic [WORD_W-1:0]       tgt_word_reg;
    logic [BIT_W-1:0]        tgt_bit_reg;
    logic [WORD_BITS-1:0]    rd_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]       result_addr_reg;
    status_code_t            status_reg;

    logic [WORD_BITS-1:0]    bitmap_mem [BITMAP_WORDS];

    logic accept;
    logic out_free;

    assign accept    = cmd.req_ready && req.valid;
    assign req.ready = cmd.req_ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // ------------------------------------------------------------------
    // arena limits
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] eff_pages  [ARENA_COUNT];
    logic [CNT_W-1:0] word_count [ARENA_COUNT];

    always_comb
    begin
        for (int a = 0; a < ARENA_COUNT; a++)
        begin
            eff_pages[a]  = (CNT_W'(arena_cfg[a].pages) > CNT_W'(PAGES_PER_ARENA)) ?
                            CNT_W'(PAGES_PER_ARENA) : CNT_W'(arena_cfg[a].pages);
            word_count[a] = (eff_pages[a] + CNT_W'(WORD_BITS - 1)) >> BIT_W;
        end
    end

    // ------------------------------------------------------------------
    // first word that is not full or skipped, in arena then word order
    // ------------------------------------------------------------------
    logic [BITMAP_WORDS-1:0] cand;
    logic [BITMAP_WORDS-1:0] cand_low;
    logic [IDX_W-1:0]        srch_idx;
    logic [ARENA_W-1:0]      srch_arena;
    logic [WORD_W-1:0]       srch_word;

    always_comb
    begin
        for (int a = 0; a < ARENA_COUNT; a++)
        begin
            for (int w = 0; w < WPA; w++)
            begin
                cand[a*WPA + w] = (CNT_W'(w) < word_count[a]) &&
                                  !full_reg[a*WPA + w] && !skip_reg[a*WPA + w];
            end
        end
        cand_low   = cand & (~cand + 1'b1);
        srch_idx   = '0;
        srch_arena = '0;
        srch_word  = '0;
        for (int i = 0; i < BITMAP_WORDS; i++)
        begin
            if (cand_low[i])
            begin
                srch_idx   = srch_idx   | IDX_W'(i);
                srch_arena = srch_arena | ARENA_W'(i / WPA);
                srch_word  = srch_word  | WORD_W'(i % WPA);
            end
        end
    end

    // ------------------------------------------------------------------
    // arena holding a page for free and reserve; first arena wins
    // ------------------------------------------------------------------
    logic [BASE_W-1:0] frame;
    logic [BASE_W:0]   diff [ARENA_COUNT];
    logic              loc_hit;
    logic [ARENA_W-1:0] loc_arena;
    logic [PAGE_W-1:0] loc_page;
    logic [IDX_W-1:0]  loc_idx;

    assign frame = addr_reg[ADDR_W-1:PAGE_OFS_W];

    always_comb
    begin
        loc_hit   = 1'b0;
        loc_arena = '0;
        loc_page  = '0;
        loc_idx   = '0;
        for (int a = ARENA_COUNT - 1; a >= 0; a--)
        begin
            diff[a] = {1'b0, frame} - {1'b0, arena_cfg[a].base_frame};
            if (!diff[a][BASE_W] && (diff[a][BASE_W-1:0] < BASE_W'(eff_pages[a])))
            begin
                loc_hit   = 1'b1;
                loc_arena = ARENA_W'(a);
                loc_page  = diff[a][PAGE_W-1:0];
                loc_idx   = IDX_W'(a * WPA) + IDX_W'(diff[a][PAGE_W-1:0] >> BIT_W);
            end
        end
    end

    // ------------------------------------------------------------------
    // word update
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]     remain;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_bit;
    logic [BIT_W-1:0]     free_idx;
    logic [WORD_BITS-1:0] mark_mask;
    logic [WORD_BITS-1:0] new_word;
    logic [BASE_W-1:0]    alloc_frame;
    logic [ADDR_W-1:0]    alloc_addr;
    status_code_t         plain_status;

    always_comb
    begin
        remain     = eff_pages[tgt_arena_reg] - (CNT_W'(tgt_word_reg) << BIT_W);
        valid_mask = (remain >= CNT_W'(WORD_BITS)) ? '1 :
                     ((WORD_BITS'(1) << remain[BIT_W-1:0]) - WORD_BITS'(1));
        free_bits  = ~rd_data_reg & valid_mask;
        low_bit    = free_bits & (~free_bits + 1'b1);
        free_idx   = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_bit[b])
            begin
                free_idx = free_idx | BIT_W'(b);
            end
        end
        alloc_frame = arena_cfg[tgt_arena_reg].base_frame +
                      BASE_W'({tgt_word_reg, free_idx});
        alloc_addr  = {alloc_frame, {PAGE_OFS_W{1'b0}}};
        mark_mask   = WORD_BITS'(1) << tgt_bit_reg;
        case (op_reg)
            CMD_ALLOC: new_word = rd_data_reg | low_bit;
            CMD_FREE:  new_word = rd_data_reg & ~mark_mask;
            default:   new_word = rd_data_reg | mark_mask;
        endcase
        case (op_reg)
            CMD_ALLOC:             plain_status = ST_OOM;
            CMD_FREE, CMD_RESERVE: plain_status = misaligned_reg ? ST_MISALIGNED : ST_OUTSIDE;
            default:               plain_status = ST_OK;
        endcase
    end

    // ------------------------------------------------------------------
    // bitmap memory, cleared word by word after reset
    // ------------------------------------------------------------------
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign mem_we    = cmd.clear_step || cmd.mem_write;
    assign mem_waddr = cmd.clear_step ? clear_idx_reg : tgt_idx_reg;
    assign mem_wdata = cmd.clear_step ? '0 : new_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= bitmap_mem[tgt_idx_reg];
        end
    end

    // ------------------------------------------------------------------
    // summary vectors and response valid
    // ------------------------------------------------------------------
    always_comb
    begin
        full_next = full_reg;
        if (cmd.mem_write)
        begin
            full_next[tgt_idx_reg] = (new_word == '1);
        end
        skip_next = skip_reg;
        if (accept)
        begin
            skip_next = '0;
        end
        else if (cmd.skip_word)
        begin
            // partial last word with no page left under the count
            skip_next[tgt_idx_reg] = 1'b1;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg      <= '0;
            skip_reg      <= '0;
            clear_idx_reg <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            loc_ok_reg    <= 1'b0;
        end
        else
        begin
            full_reg      <= full_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clear_step)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
            end
            if (cmd.search)
            begin
                found_reg <= |cand;
            end
            if (cmd.locate)
            begin
                loc_ok_reg <= !(|addr_reg[PAGE_OFS_W-1:0]) && loc_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.command;
            addr_reg <= req.phys_addr;
        end
        if (cmd.search)
        begin
            tgt_idx_reg   <= srch_idx;
            tgt_arena_reg <= srch_arena;
            tgt_word_reg  <= srch_word;
        end
        if (cmd.locate)
        begin
            misaligned_reg <= |addr_reg[PAGE_OFS_W-1:0];
            tgt_idx_reg    <= loc_idx;
            tgt_arena_reg  <= loc_arena;
            tgt_bit_reg    <= loc_page[BIT_W-1:0];
        end
        if (cmd.out_load)
        begin
            if (cmd.out_sel == OUT_SEL_EVAL)
            begin
                result_addr_reg <= (op_reg == CMD_ALLOC) ? alloc_addr : '0;
                status_reg      <= ST_OK;
            end
            else
            begin
                result_addr_reg <= '0;
                status_reg      <= plain_status;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_addr = result_addr_reg;
    assign rsp.status      = status_reg;

    assign status.req_valid      = req.valid;
    assign status.req_command    = req.command;
    assign status.clear_last     = (clear_idx_reg == IDX_W'(BITMAP_WORDS - 1));
    assign status.target_ok      = (op_reg == CMD_ALLOC) ? found_reg : loc_ok_reg;
    assign status.word_exhausted = (op_reg == CMD_ALLOC) && (free_bits == '0);
    assign status.out_free       = out_free;

endmodule

[rtl/bpfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer of the page frame allocator: clearing pass, search or lookup,
// read, update and response load.
// ----------------------------------------------------------------------------
module bpfa_ctrl import bpfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.out_sel = OUT_SEL_EVAL;
        state_next = state_reg;
        case (state_reg)
            FSM_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                cmd.req_ready = 1'b1;
                if (status.req_valid)
                begin
                    case (status.req_command)
                        CMD_ALLOC:             state_next = FSM_SEARCH;
                        CMD_FREE, CMD_RESERVE: state_next = FSM_LOCATE;
                        default:               state_next = FSM_REPLY;
                    endcase
                end
            end
            FSM_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = FSM_READ;
            end
            FSM_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = FSM_READ;
            end
            FSM_READ:
            begin
                if (status.target_ok)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = FSM_EVAL;
                end
                else
                begin
                    state_next = FSM_REPLY;
                end
            end
            FSM_EVAL:
            begin
                if (status.word_exhausted)
                begin
                    cmd.skip_word = 1'b1;
                    state_next    = FSM_SEARCH;
                end
                else if (status.out_free)
                begin
                    cmd.mem_write = 1'b1;
                    cmd.out_load  = 1'b1;
                    state_next    = FSM_IDLE;
                end
            end
            FSM_REPLY:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_SEL_PLAIN;
                    state_next   = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

[rtl/bpfa_checker.sv]
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level checks of the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpfa_checker import bpfa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ADDR_W-1:0] rsp_result_addr,
    input logic [1:0]        rsp_status
);

    // beats taken in but not yet delivered
    logic [1:0] outstanding_reg, outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_addr) && $stable(rsp_status))
        else $error("response changed while stalled");

    a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_result_addr == '0)
        else $error("nonzero address with error status");

    a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_result_addr[PAGE_OFS_W-1:0] == '0)
        else $error("result address not page aligned");

    a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 2'd0)
        else $error("response without a request");

    a_depth_two: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 2'd2 |-> !req_ready)
        else $error("request taken with two beats outstanding");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_result_addr (rsp.result_addr),
    .rsp_status      (rsp.status)
);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit page frame allocator. A frame ledger
// mirrors the used-page bitmap and arena setup, works out the reply to every
// accepted command and matches replies in order. Directed cases come first,
// then random phases under several arena layouts and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import bpfa_pkg::*;

    localparam int WORDS_PER_ARENA = (PAGES_PER_ARENA_DEF + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_WORDS     = ARENA_COUNT_DEF * WORDS_PER_ARENA;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        status_code_t      status;
    } page_reply_t;

    class frame_ledger;
        logic [WORD_BITS-1:0] used_words [TOTAL_WORDS];
        logic [BASE_W-1:0]    base_frame [ARENA_COUNT_DEF];
        logic [PAGES_W-1:0]   page_count [ARENA_COUNT_DEF];
        page_reply_t          awaited [$];
        int                   mismatches;

        function new();
            foreach (used_words[i]) used_words[i] = '0;
            foreach (base_frame[i])
            begin
                base_frame[i] = '0;
                page_count[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_ARENA0_BASE:  base_frame[0] = value[BASE_W-1:0];
                REG_ARENA0_PAGES: page_count[0] = value[PAGES_W-1:0];
                REG_ARENA1_BASE:  base_frame[1] = value[BASE_W-1:0];
                REG_ARENA1_PAGES: page_count[1] = value[PAGES_W-1:0];
                default:          ;
            endcase
        endfunction

        // counts above the arena size are clamped
        function int unsigned usable_pages(int a);
            if (page_count[a] > PAGES_PER_ARENA_DEF)
                return PAGES_PER_ARENA_DEF;
            return page_count[a];
        endfunction

        function page_reply_t grant_frame();
            page_reply_t          r;
            int unsigned          pages;
            int unsigned          words;
            int unsigned          remain;
            logic [WORD_BITS-1:0] open_bits;
            logic [31:0]          frame;
            r.addr   = '0;
            r.status = ST_OOM;
            for (int a = 0; a < ARENA_COUNT_DEF; a++)
            begin
                pages = usable_pages(a);
                words = (pages + WORD_BITS - 1) / WORD_BITS;
                for (int w = 0; w < words; w++)
                begin
                    remain = pages - w * WORD_BITS;
                    open_bits = ~used_words[a * WORDS_PER_ARENA + w];
                    if (remain < WORD_BITS)
                        open_bits = open_bits & ((32'd1 << remain) - 32'd1);
                    for (int b = 0; b < WORD_BITS; b++)
                    begin
                        if (open_bits[b])
                        begin
                            used_words[a * WORDS_PER_ARENA + w][b] = 1'b1;
                            frame    = base_frame[a] + w * WORD_BITS + b;
                            r.addr   = frame << PAGE_OFS_W;   // wraps at 4 GiB
                            r.status = ST_OK;
                            return r;
                        end
                    end
                end
            end
            return r;
        endfunction

        function page_reply_t mark_frame(logic [ADDR_W-1:0] addr, logic used);
            page_reply_t        r;
            logic [BASE_W-1:0]  frame;
            int unsigned        offset;
            r.addr = '0;
            if (addr[PAGE_OFS_W-1:0] != '0)
            begin
                r.status = ST_MISALIGNED;
                return r;
            end
            frame = addr[ADDR_W-1:PAGE_OFS_W];
            // first arena holding the frame wins when arenas overlap
            for (int a = 0; a < ARENA_COUNT_DEF; a++)
            begin
                if (frame >= base_frame[a])
                begin
                    offset = frame - base_frame[a];
                    if (offset < usable_pages(a))
                    begin
                        used_words[a * WORDS_PER_ARENA + offset / WORD_BITS]
                            [offset % WORD_BITS] = used;
                        r.status = ST_OK;
                        return r;
                    end
                end
            end
            r.status = ST_OUTSIDE;
            return r;
        endfunction

        function void note_command(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
            page_reply_t r;
            case (cmd)
                CMD_ALLOC:   r = grant_frame();
                CMD_FREE:    r = mark_frame(addr, 1'b0);
                CMD_RESERVE: r = mark_frame(addr, 1'b1);
                default:
                begin
                    r.addr   = '0;
                    r.status = ST_OK;
                end
            endcase
            awaited.push_back(r);
        endfunction

        task flag_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_reply(logic [ADDR_W-1:0] addr, logic [1:0] status);
            page_reply_t want;
            if (awaited.size() == 0)
            begin
                flag_mismatch($sformatf("reply addr %h status %0d with nothing pending",
                                        addr, status));
                return;
            end
            want = awaited.pop_front();
            if (addr !== want.addr)
                flag_mismatch($sformatf("result_addr %h, expected %h", addr, want.addr));
            if (status !== want.status)
                flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    bpfa_req_if req_bus ();
    bpfa_rsp_if rsp_bus ();

    frame_ledger ledger = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    bitmap_page_frame_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_bus),
        .rsp     (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send_request(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_bus.valid     <= 1'b1;
        req_bus.command   <= cmd;
        req_bus.phys_addr <= addr;
        do @(posedge clk); while (!req_bus.ready);
        ledger.note_command(cmd, addr);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        do @(posedge clk); while (ledger.awaited.size() != 0);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ledger.set_register(idx, value);
    endtask

    // bits above each field carry junk, the block must drop them
    task automatic program_arenas(input logic [BASE_W-1:0] b0, input logic [PAGES_W-1:0] p0,
                                  input logic [BASE_W-1:0] b1, input logic [PAGES_W-1:0] p1);
        write_register(REG_ARENA0_BASE,  {12'($urandom), b0});
        write_register(REG_ARENA0_PAGES, {21'($urandom), p0});
        write_register(REG_ARENA1_BASE,  {12'($urandom), b1});
        write_register(REG_ARENA1_PAGES, {21'($urandom), p1});
    endtask

    task automatic run_random(input int count);
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       frame;
        int unsigned       pick;
        int unsigned       which;
        int unsigned       span;
        repeat (count)
        begin
            pick  = $urandom_range(99);
            which = $urandom_range(CFG_ARENAS - 1);
            // aim near the low pages of an arena, where allocations land
            span  = ledger.usable_pages(which) + 1;
            if (span > 48 && $urandom_range(3) != 0)
                span = 48;
            frame = ledger.base_frame[which] + $urandom_range(span);
            addr  = frame << PAGE_OFS_W;
            if (pick < 45)
            begin
                cmd  = CMD_ALLOC;
                addr = $urandom();
            end
            else if (pick < 65)
                cmd = CMD_FREE;
            else if (pick < 80)
                cmd = CMD_RESERVE;
            else if (pick < 88)
            begin
                cmd  = $urandom_range(1) ? CMD_FREE : CMD_RESERVE;
                addr = $urandom();
            end
            else if (pick < 95)
            begin
                cmd = $urandom_range(1) ? CMD_FREE : CMD_RESERVE;
                addr[PAGE_OFS_W-1:0] = 12'd1 << $urandom_range(PAGE_OFS_W - 1);
            end
            else
            begin
                cmd  = CMD_UNUSED;
                addr = $urandom();
            end
            send_request(cmd, addr);
        end
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct, input int count,
                             input logic [BASE_W-1:0] b0, input logic [PAGES_W-1:0] p0,
                             input logic [BASE_W-1:0] b1, input logic [PAGES_W-1:0] p1);
        wait_drained();
        program_arenas(b0, p0, b1, p1);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        run_random(count);
    endtask

    // reply side: random stalls, every beat checked in order
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_bus.valid && rsp_bus.ready)
                ledger.check_reply(rsp_bus.result_addr, rsp_bus.status);
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.command   <= CMD_ALLOC;
        req_bus.phys_addr <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // no arena configured yet
        send_request(CMD_ALLOC, 32'h0000_0000);
        send_request(CMD_FREE,  32'h0000_0000);
        wait_drained();

        // arena zero straddles the top of the address space, arena one
        // has a page count above the arena size
        program_arenas(20'hFFFFF, 11'd2, 20'h00100, 11'd2047);
        send_request(CMD_ALLOC,   32'h0000_0000);
        send_request(CMD_ALLOC,   32'hFFFF_FFFF);   // wraps to address zero
        send_request(CMD_ALLOC,   32'h0000_0000);
        send_request(CMD_FREE,    32'h0000_0000);   // wrapped frame is in no arena
        send_request(CMD_FREE,    32'hFFFF_F000);
        send_request(CMD_FREE,    32'hFFFF_F000);   // already free
        send_request(CMD_RESERVE, 32'h0010_1000);
        send_request(CMD_RESERVE, 32'h0010_1000);   // already used
        send_request(CMD_ALLOC,   32'h0000_0000);
        send_request(CMD_ALLOC,   32'h0000_0000);   // skips the reserved page
        send_request(CMD_FREE,    32'h0010_0800);
        send_request(CMD_RESERVE, 32'hFFFF_FFFF);
        send_request(CMD_FREE,    32'h0050_0000);   // one past the clamped count
        send_request(CMD_RESERVE, 32'h004F_F000);   // last clamped page
        send_request(CMD_UNUSED,  32'hFFFF_FFFF);
        send_request(CMD_UNUSED,  32'h0000_0000);
        send_request(CMD_FREE,    32'h000F_F000);   // just below arena one
        send_request(CMD_ALLOC,   32'h0000_0000);

        // overlapping arenas, partial last words
        run_phase(0,  0,  200, 20'h00000, 11'd40,   20'h00020, 11'd33);
        run_phase(69, 0,  200, 20'hFFFF0, 11'd20,   20'h12345, 11'd64);
        // counts shrink under pages still marked used
        run_phase(0,  69, 200, 20'hFFFF0, 11'd10,   20'h12345, 11'd1);
        run_phase(28, 28, 250, 20'hFFFFF, 11'd1024, 20'h00000, 11'd0);
        run_phase(0,  0,  150, 20'h80000, 11'd2047, 20'h7FFFF, 11'd1500);
        run_phase(28, 28, 150, 20'h00001, 11'd0,    20'h00001, 11'd3);

        wait_drained();
        repeat (8) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/bpfa_pkg.sv
rtl/bpfa_if.sv
rtl/bpfa_regs.sv
rtl/bpfa_datapath.sv
rtl/bpfa_ctrl.sv
rtl/bitmap_page_frame_allocator.sv
rtl/bpfa_checker.sv
test/tb_top.sv
